// ----- rtl/core/tpsb_pkg.sv -----
package tpsb_pkg;

   localparam int unsigned CHANNELS = 3;

   typedef logic [7:0]  unorm8_type;
   typedef logic [15:0] q16_type;
   typedef logic [2:0]  csr_index_type;

   // register indexes of the configuration port
   localparam csr_index_type CSR_TINT_RED     = 3'd0;
   localparam csr_index_type CSR_TINT_GREEN   = 3'd1;
   localparam csr_index_type CSR_TINT_BLUE    = 3'd2;
   localparam csr_index_type CSR_TINT_ALPHA   = 3'd3;
   localparam csr_index_type CSR_BLEND_SELECT = 3'd4;
   localparam csr_index_type CSR_GRAY_ENABLE  = 3'd5;

   // blend modes, the unused code falls back to source-over
   localparam logic [1:0] BLEND_OVER     = 2'd0;
   localparam logic [1:0] BLEND_ADD      = 2'd1;
   localparam logic [1:0] BLEND_MULTIPLY = 2'd2;

   // rec 601 luma weights, summing to 65536
   localparam logic [15:0] LUMA_RED   = 16'd19595;
   localparam logic [15:0] LUMA_GREEN = 16'd38470;
   localparam logic [15:0] LUMA_BLUE  = 16'd7471;

   localparam q16_type ONE_Q16 = 16'hFFFF;

   typedef struct packed {
      unorm8_type [CHANNELS-1:0] tint;
      unorm8_type                tint_alpha;
      logic [1:0]                blend_select;
      logic                      gray_enable;
   } cfg_type;

   typedef struct packed {
      q16_type    [CHANNELS-1:0] src;
      q16_type                   alpha;
      unorm8_type [CHANNELS-1:0] dest;
   } src_beat_type;

   function automatic q16_type widen8(input unorm8_type v);
      return {v, v};
   endfunction

   function automatic q16_type qmul(input q16_type x, input q16_type y);
      logic [31:0] p;
      p = x * y;
      return p[31:16];
   endfunction

endpackage

// ----- rtl/core/tpsb_req_if.sv -----
interface tpsb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] texel_red;
   logic [7:0] texel_green;
   logic [7:0] texel_blue;
   logic [7:0] texel_alpha;
   logic [7:0] shape_mask;
   logic [7:0] dest_red;
   logic [7:0] dest_green;
   logic [7:0] dest_blue;

   modport source (
      output valid, texel_red, texel_green, texel_blue, texel_alpha, shape_mask,
             dest_red, dest_green, dest_blue,
      input  ready
   );
   modport sink (
      input  valid, texel_red, texel_green, texel_blue, texel_alpha, shape_mask,
             dest_red, dest_green, dest_blue,
      output ready
   );
endinterface

// ----- rtl/core/tpsb_rsp_if.sv -----
interface tpsb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;

   modport source (
      output valid, out_red, out_green, out_blue,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue,
      output ready
   );
endinterface

// ----- rtl/core/tpsb_csr_if.sv -----
interface tpsb_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ----- rtl/core/tpsb_csr_regs.sv -----
module tpsb_csr_regs (
   input  logic              clock,
   input  logic              reset,
   tpsb_csr_if.sink          csr_bus,
   output tpsb_pkg::cfg_type cfg
);

   tpsb_pkg::cfg_type cfg_ff;
   tpsb_pkg::cfg_type cfg_in;
   logic              write;

   assign csr_bus.ready = 1'b1;
   assign write = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_bus.index)
            tpsb_pkg::CSR_TINT_RED:     cfg_in.tint[0] = csr_bus.data;
            tpsb_pkg::CSR_TINT_GREEN:   cfg_in.tint[1] = csr_bus.data;
            tpsb_pkg::CSR_TINT_BLUE:    cfg_in.tint[2] = csr_bus.data;
            tpsb_pkg::CSR_TINT_ALPHA:   cfg_in.tint_alpha = csr_bus.data;
            tpsb_pkg::CSR_BLEND_SELECT: cfg_in.blend_select = csr_bus.data[1:0];
            tpsb_pkg::CSR_GRAY_ENABLE:  cfg_in.gray_enable = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tint         <= {tpsb_pkg::CHANNELS{8'hFF}};
         cfg_ff.tint_alpha   <= 8'hFF;
         cfg_ff.blend_select <= tpsb_pkg::BLEND_OVER;
         cfg_ff.gray_enable  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

`ifndef SYNTHESIS
   a_blend_write: assert property (@(posedge clock) disable iff (reset)
      (write && csr_bus.index == tpsb_pkg::CSR_BLEND_SELECT)
      |=> cfg_ff.blend_select == $past(csr_bus.data[1:0]))
      else $error("blend select write lost");
`endif

endmodule

// ----- rtl/core/tpsb_source_stages.sv -----
module tpsb_source_stages (
   input  logic                   clock,
   input  logic                   reset,
   input  tpsb_pkg::cfg_type      cfg,
   tpsb_req_if.sink               req_bus,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output tpsb_pkg::src_beat_type dn_beat
);

   localparam int unsigned N = tpsb_pkg::CHANNELS;

   // stage 1: alpha times mask, luma partial products
   logic                         s1_valid_ff, s1_valid_in, s1_load;
   tpsb_pkg::unorm8_type [N-1:0] s1_tex_ff, s1_tex_in;
   tpsb_pkg::unorm8_type [N-1:0] s1_dest_ff, s1_dest_in;
   tpsb_pkg::q16_type            s1_alpha_ff, s1_alpha_in;
   logic [N-1:0][31:0]           s1_luma_ff, s1_luma_in;

   // stage 2: gray select, tint alpha
   logic                         s2_valid_ff, s2_valid_in, s2_load;
   tpsb_pkg::q16_type [N-1:0]    s2_col_ff, s2_col_in;
   tpsb_pkg::unorm8_type [N-1:0] s2_dest_ff, s2_dest_in;
   tpsb_pkg::q16_type            s2_alpha_ff, s2_alpha_in;

   // stage 3: color tint
   logic                         s3_valid_ff, s3_valid_in, s3_load;
   tpsb_pkg::src_beat_type       s3_beat_ff, s3_beat_in;

   logic [31:0]                  luma_sum;
   tpsb_pkg::q16_type            luma;

   assign s3_load = !s3_valid_ff || dn_ready;
   assign s2_load = !s2_valid_ff || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;
   assign req_bus.ready = s1_load;

   always_comb begin
      s1_valid_in   = req_bus.valid;
      s1_tex_in[0]  = req_bus.texel_red;
      s1_tex_in[1]  = req_bus.texel_green;
      s1_tex_in[2]  = req_bus.texel_blue;
      s1_dest_in[0] = req_bus.dest_red;
      s1_dest_in[1] = req_bus.dest_green;
      s1_dest_in[2] = req_bus.dest_blue;
      s1_alpha_in   = tpsb_pkg::qmul(tpsb_pkg::widen8(req_bus.texel_alpha),
                                     tpsb_pkg::widen8(req_bus.shape_mask));
      s1_luma_in[0] = tpsb_pkg::LUMA_RED * tpsb_pkg::widen8(req_bus.texel_red);
      s1_luma_in[1] = tpsb_pkg::LUMA_GREEN * tpsb_pkg::widen8(req_bus.texel_green);
      s1_luma_in[2] = tpsb_pkg::LUMA_BLUE * tpsb_pkg::widen8(req_bus.texel_blue);
   end

   // the weights sum to 65536, so the sum stays below 2^32
   assign luma_sum = s1_luma_ff[0] + s1_luma_ff[1] + s1_luma_ff[2];
   assign luma     = luma_sum[31:16];

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_dest_in  = s1_dest_ff;
      s2_alpha_in = tpsb_pkg::qmul(s1_alpha_ff, tpsb_pkg::widen8(cfg.tint_alpha));
      for (int c = 0; c < N; c++) begin
         s2_col_in[c] = cfg.gray_enable ? luma : tpsb_pkg::widen8(s1_tex_ff[c]);
      end
   end

   always_comb begin
      s3_valid_in      = s2_valid_ff;
      s3_beat_in.dest  = s2_dest_ff;
      s3_beat_in.alpha = s2_alpha_ff;
      for (int c = 0; c < N; c++) begin
         s3_beat_in.src[c] = tpsb_pkg::qmul(s2_col_ff[c], tpsb_pkg::widen8(cfg.tint[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_load) begin
            s2_valid_ff <= s2_valid_in;
         end
         if (s3_load) begin
            s3_valid_ff <= s3_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_tex_ff   <= s1_tex_in;
         s1_dest_ff  <= s1_dest_in;
         s1_alpha_ff <= s1_alpha_in;
         s1_luma_ff  <= s1_luma_in;
      end
      if (s2_load) begin
         s2_col_ff   <= s2_col_in;
         s2_dest_ff  <= s2_dest_in;
         s2_alpha_ff <= s2_alpha_in;
      end
      if (s3_load) begin
         s3_beat_ff <= s3_beat_in;
      end
   end

   assign dn_valid = s3_valid_ff;
   assign dn_beat  = s3_beat_ff;

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> s1_valid_ff)
      else $error("accepted beat did not enter stage 1");

   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_valid_ff && cfg.gray_enable)
      |=> (s2_col_ff[0] == s2_col_ff[1] && s2_col_ff[1] == s2_col_ff[2]))
      else $error("gray channels differ");
`endif

endmodule

// ----- rtl/core/tpsb_blend_stages.sv -----
module tpsb_blend_stages (
   input  logic                   clock,
   input  logic                   reset,
   input  tpsb_pkg::cfg_type      cfg,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  tpsb_pkg::src_beat_type up_beat,
   tpsb_rsp_if.source             rsp_bus
);

   localparam int unsigned N = tpsb_pkg::CHANNELS;

   // stage 4: blend products
   logic                         s4_valid_ff, s4_valid_in, s4_load;
   tpsb_pkg::q16_type [N-1:0]    s4_src_ff, s4_src_in;
   tpsb_pkg::q16_type [N-1:0]    s4_dst_ff, s4_dst_in;
   tpsb_pkg::q16_type [N-1:0]    s4_wdest_ff, s4_wdest_in;

   // stage 5: combine, clamp, round
   logic                         s5_valid_ff, s5_valid_in, s5_load;
   tpsb_pkg::unorm8_type [N-1:0] s5_out_ff, s5_out_in;

   tpsb_pkg::q16_type            inv_alpha;

   assign s5_load  = !s5_valid_ff || rsp_bus.ready;
   assign s4_load  = !s4_valid_ff || s5_load;
   assign up_ready = s4_load;

   assign inv_alpha = tpsb_pkg::ONE_Q16 - up_beat.alpha;

   always_comb begin
      tpsb_pkg::q16_type wd;
      s4_valid_in = up_valid;
      for (int c = 0; c < N; c++) begin
         wd = tpsb_pkg::widen8(up_beat.dest[c]);
         s4_wdest_in[c] = wd;
         s4_src_in[c]   = tpsb_pkg::qmul(up_beat.src[c], up_beat.alpha);
         s4_dst_in[c]   = (cfg.blend_select == tpsb_pkg::BLEND_MULTIPLY)
                        ? tpsb_pkg::qmul(wd, up_beat.src[c])
                        : tpsb_pkg::qmul(wd, inv_alpha);
      end
   end

   always_comb begin
      logic [16:0]       mix;
      tpsb_pkg::q16_type clip;
      logic [23:0]       scaled;
      s5_valid_in = s4_valid_ff;
      for (int c = 0; c < N; c++) begin
         case (cfg.blend_select)
            tpsb_pkg::BLEND_ADD:      mix = {1'b0, s4_wdest_ff[c]} + {1'b0, s4_src_ff[c]};
            tpsb_pkg::BLEND_MULTIPLY: mix = {s4_dst_ff[c], 1'b0};
            default:                  mix = {1'b0, s4_src_ff[c]} + {1'b0, s4_dst_ff[c]};
         endcase
         clip   = mix[16] ? tpsb_pkg::ONE_Q16 : mix[15:0];
         // clip * 255 + half
         scaled = {clip, 8'h00} - {8'h00, clip} + 24'h008000;
         s5_out_in[c] = scaled[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s4_load) begin
            s4_valid_ff <= s4_valid_in;
         end
         if (s5_load) begin
            s5_valid_ff <= s5_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_load) begin
         s4_src_ff   <= s4_src_in;
         s4_dst_ff   <= s4_dst_in;
         s4_wdest_ff <= s4_wdest_in;
      end
      if (s5_load) begin
         s5_out_ff <= s5_out_in;
      end
   end

   assign rsp_bus.valid     = s5_valid_ff;
   assign rsp_bus.out_red   = s5_out_ff[0];
   assign rsp_bus.out_green = s5_out_ff[1];
   assign rsp_bus.out_blue  = s5_out_ff[2];

`ifndef SYNTHESIS
   a_stage4_moves: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && s5_load) |=> s5_valid_ff)
      else $error("beat lost between stage 4 and output");
`endif

endmodule

// ----- rtl/core/textured_pixel_shade_blend_core.sv -----
// Per-pixel texel combiner: takes an RGBA8 texel, a mask alpha and the destination RGB, optionally
// turns the texel into its luma, applies the RGBA tint and blends source-over, additive or doubled
// multiply, returning clamped and rounded 8-bit RGB (alpha is implied 255). Five register stages
// from an accepted req beat to its rsp beat, one pixel per clock sustained while rsp is ready; the
// stage chain stalls only where a downstream stage is occupied and not advancing, and bubbles
// collapse. Registers (tint, blend mode, gray enable) are written through the csr channel, which
// is always ready, and should be changed only while no pixel is in flight.
module textured_pixel_shade_blend_core (
   input  logic       clock,
   input  logic       reset,
   tpsb_req_if.sink   req_bus,
   tpsb_rsp_if.source rsp_bus,
   tpsb_csr_if.sink   csr_bus
);

   tpsb_pkg::cfg_type      cfg;
   logic                   mid_valid;
   logic                   mid_ready;
   tpsb_pkg::src_beat_type mid_beat;

   tpsb_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tpsb_source_stages u_source (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_bus  (req_bus),
      .dn_valid (mid_valid),
      .dn_ready (mid_ready),
      .dn_beat  (mid_beat)
   );

   tpsb_blend_stages u_blend (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (mid_valid),
      .up_ready (mid_ready),
      .up_beat  (mid_beat),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ----- verif/tb_textured_pixel_shade_blend_core.sv -----
typedef struct packed {
   logic [7:0] texel_red;
   logic [7:0] texel_green;
   logic [7:0] texel_blue;
   logic [7:0] texel_alpha;
   logic [7:0] shape_mask;
   logic [7:0] dest_red;
   logic [7:0] dest_green;
   logic [7:0] dest_blue;
} texel_beat_type;

typedef struct packed {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
} rgb_beat_type;

class shade_scoreboard;
   tpsb_pkg::unorm8_type tint_red;
   tpsb_pkg::unorm8_type tint_green;
   tpsb_pkg::unorm8_type tint_blue;
   tpsb_pkg::unorm8_type tint_alpha;
   logic [1:0]           blend_select;
   logic                 gray_enable;
   rgb_beat_type         expected_rgb[$];
   int                   errors;

   function new();
      tint_red     = 8'd255;
      tint_green   = 8'd255;
      tint_blue    = 8'd255;
      tint_alpha   = 8'd255;
      blend_select = tpsb_pkg::BLEND_OVER;
      gray_enable  = 1'b0;
      errors       = 0;
   endfunction

   function void write_reg(tpsb_pkg::csr_index_type index, tpsb_pkg::unorm8_type data);
      case (index)
         tpsb_pkg::CSR_TINT_RED:     tint_red = data;
         tpsb_pkg::CSR_TINT_GREEN:   tint_green = data;
         tpsb_pkg::CSR_TINT_BLUE:    tint_blue = data;
         tpsb_pkg::CSR_TINT_ALPHA:   tint_alpha = data;
         tpsb_pkg::CSR_BLEND_SELECT: blend_select = data[1:0];
         tpsb_pkg::CSR_GRAY_ENABLE:  gray_enable = data[0];
         default: ;
      endcase
   endfunction

   // unorm8 to q0.16
   static function bit [31:0] expand(bit [7:0] v);
      return v * 32'd257;
   endfunction

   static function bit [31:0] scale(bit [31:0] x, bit [31:0] y);
      bit [63:0] p;
      p = x * y;
      return p[47:16];
   endfunction

   // clamp to one, back to unorm8 with rounding
   static function bit [7:0] to_unorm(bit [31:0] x);
      bit [31:0] c;
      c = (x > 32'd65535) ? 32'd65535 : x;
      return 8'((c * 32'd255 + 32'd32768) >> 16);
   endfunction

   function rgb_beat_type shade(texel_beat_type p);
      bit [31:0] chan [3];
      bit [31:0] dst [3];
      bit [7:0]  tint [3];
      bit [7:0]  outv [3];
      bit [31:0] alpha;
      bit [31:0] mixed;
      bit [63:0] luma;
      rgb_beat_type res;
      chan[0] = expand(p.texel_red);
      chan[1] = expand(p.texel_green);
      chan[2] = expand(p.texel_blue);
      dst[0]  = expand(p.dest_red);
      dst[1]  = expand(p.dest_green);
      dst[2]  = expand(p.dest_blue);
      tint[0] = tint_red;
      tint[1] = tint_green;
      tint[2] = tint_blue;
      alpha = scale(expand(p.texel_alpha), expand(p.shape_mask));
      if (gray_enable) begin
         luma = (64'd19595 * chan[0] + 64'd38470 * chan[1] + 64'd7471 * chan[2]) >> 16;
         for (int i = 0; i < 3; i++) chan[i] = luma[31:0];
      end
      for (int i = 0; i < 3; i++) chan[i] = scale(chan[i], expand(tint[i]));
      alpha = scale(alpha, expand(tint_alpha));
      for (int i = 0; i < 3; i++) begin
         case (blend_select)
            tpsb_pkg::BLEND_ADD:      mixed = dst[i] + scale(chan[i], alpha);
            tpsb_pkg::BLEND_MULTIPLY: mixed = scale(dst[i], chan[i]) << 1;
            default:                  mixed = scale(chan[i], alpha) +
                                              scale(dst[i], 32'd65535 - alpha);
         endcase
         outv[i] = to_unorm(mixed);
      end
      res.red   = outv[0];
      res.green = outv[1];
      res.blue  = outv[2];
      return res;
   endfunction

   function void note_pixel(texel_beat_type p);
      expected_rgb.push_back(shade(p));
   endfunction

   function int pending();
      return expected_rgb.size();
   endfunction

   task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
   endtask

   task check_rgb(rgb_beat_type got);
      rgb_beat_type want;
      if (expected_rgb.size() == 0) begin
         report_mismatch("rsp beat with nothing pending, red", got.red, 8'd0);
      end else begin
         want = expected_rgb.pop_front();
         if (got.red !== want.red) report_mismatch("out_red", got.red, want.red);
         if (got.green !== want.green) report_mismatch("out_green", got.green, want.green);
         if (got.blue !== want.blue) report_mismatch("out_blue", got.blue, want.blue);
      end
   endtask
endclass

module tb_textured_pixel_shade_blend_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]              BLEND_SPARE    = 2'd3;
   localparam tpsb_pkg::csr_index_type CSR_SPARE_LOW  = 3'd6;
   localparam tpsb_pkg::csr_index_type CSR_SPARE_HIGH = 3'd7;
   localparam int                      PHASES         = 12;
   localparam int                      PHASE_PIXELS   = 150;

   logic            clock;
   logic            reset;
   bit              steady;
   shade_scoreboard board;
   texel_beat_type  seen_pixel;
   rgb_beat_type    seen_rgb;

   tpsb_req_if req_bus();
   tpsb_rsp_if rsp_bus();
   tpsb_csr_if csr_bus();

   textured_pixel_shade_blend_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("Simulation FAILED");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= 10);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) board.write_reg(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            seen_pixel = '{req_bus.texel_red, req_bus.texel_green, req_bus.texel_blue,
                           req_bus.texel_alpha, req_bus.shape_mask, req_bus.dest_red,
                           req_bus.dest_green, req_bus.dest_blue};
            board.note_pixel(seen_pixel);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rgb = '{rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue};
            board.check_rgb(seen_rgb);
         end
      end
   end

   function automatic texel_beat_type pixel(bit [7:0] tr, bit [7:0] tg, bit [7:0] tb,
                                            bit [7:0] ta, bit [7:0] ma, bit [7:0] dr,
                                            bit [7:0] dg, bit [7:0] db);
      texel_beat_type p;
      p = '{tr, tg, tb, ta, ma, dr, dg, db};
      return p;
   endfunction

   // extremes are favored to hit saturation and zero corners
   function automatic bit [7:0] pick_unorm();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 8'd0;
      if (roll == 1) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   function automatic texel_beat_type random_pixel();
      return pixel(pick_unorm(), pick_unorm(), pick_unorm(), pick_unorm(),
                   pick_unorm(), pick_unorm(), pick_unorm(), pick_unorm());
   endfunction

   task automatic send_pixel(texel_beat_type p);
      while (!steady && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.texel_red   <= p.texel_red;
      req_bus.texel_green <= p.texel_green;
      req_bus.texel_blue  <= p.texel_blue;
      req_bus.texel_alpha <= p.texel_alpha;
      req_bus.shape_mask  <= p.shape_mask;
      req_bus.dest_red    <= p.dest_red;
      req_bus.dest_green  <= p.dest_green;
      req_bus.dest_blue   <= p.dest_blue;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_pipe();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(tpsb_pkg::csr_index_type index, tpsb_pkg::unorm8_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // junk in the unused upper bits and writes to unmapped indexes must be ignored
   task automatic setup(bit [7:0] tr, bit [7:0] tg, bit [7:0] tb, bit [7:0] ta,
                        logic [1:0] mode, bit gray);
      drain_pipe();
      csr_write(tpsb_pkg::CSR_TINT_RED, tr);
      csr_write(tpsb_pkg::CSR_TINT_GREEN, tg);
      csr_write(tpsb_pkg::CSR_TINT_BLUE, tb);
      csr_write(tpsb_pkg::CSR_TINT_ALPHA, ta);
      csr_write(tpsb_pkg::CSR_BLEND_SELECT, {6'($urandom_range(63)), mode});
      csr_write(tpsb_pkg::CSR_GRAY_ENABLE, {7'($urandom_range(127)), gray});
      csr_write(CSR_SPARE_LOW, 8'($urandom_range(255)));
      csr_write(CSR_SPARE_HIGH, 8'($urandom_range(255)));
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      steady              = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.texel_red   = 8'd0;
      req_bus.texel_green = 8'd0;
      req_bus.texel_blue  = 8'd0;
      req_bus.texel_alpha = 8'd0;
      req_bus.shape_mask  = 8'd0;
      req_bus.dest_red    = 8'd0;
      req_bus.dest_green  = 8'd0;
      req_bus.dest_blue   = 8'd0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = tpsb_pkg::CSR_TINT_RED;
      csr_bus.data        = 8'd0;
      board               = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: source-over, full tint
      send_pixel(pixel(0, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(pixel(255, 255, 255, 255, 255, 255, 255, 255));
      send_pixel(pixel(255, 128, 1, 255, 255, 0, 0, 0));
      send_pixel(pixel(200, 100, 50, 0, 255, 10, 20, 30));
      send_pixel(pixel(200, 100, 50, 255, 0, 10, 20, 30));
      send_pixel(pixel(17, 34, 51, 128, 128, 240, 120, 60));

      // additive overflow saturates
      setup(255, 255, 255, 255, tpsb_pkg::BLEND_ADD, 1'b0);
      send_pixel(pixel(255, 255, 255, 255, 255, 255, 255, 255));
      send_pixel(pixel(128, 64, 32, 128, 255, 200, 100, 0));

      // doubled multiply overflow saturates, alpha unused
      setup(255, 255, 255, 255, tpsb_pkg::BLEND_MULTIPLY, 1'b0);
      send_pixel(pixel(255, 255, 255, 255, 255, 255, 255, 255));
      send_pixel(pixel(100, 150, 200, 0, 0, 128, 128, 128));
      send_pixel(pixel(255, 0, 128, 77, 255, 255, 255, 0));

      // unused mode falls back to source-over
      setup(128, 64, 0, 200, BLEND_SPARE, 1'b0);
      send_pixel(pixel(255, 255, 255, 255, 255, 0, 128, 255));
      send_pixel(pixel(90, 180, 45, 128, 200, 60, 30, 250));

      // luma before tint
      setup(255, 255, 255, 255, tpsb_pkg::BLEND_OVER, 1'b1);
      send_pixel(pixel(255, 0, 0, 255, 255, 0, 0, 0));
      send_pixel(pixel(0, 255, 0, 255, 255, 0, 0, 0));
      send_pixel(pixel(0, 0, 255, 255, 255, 0, 0, 0));
      send_pixel(pixel(255, 255, 255, 255, 255, 0, 0, 0));

      // zero tint
      setup(0, 0, 0, 0, tpsb_pkg::BLEND_ADD, 1'b1);
      send_pixel(pixel(255, 255, 255, 255, 255, 99, 150, 201));

      setup(255, 200, 150, 255, tpsb_pkg::BLEND_OVER, 1'b0);
      send_pixel(pixel(255, 255, 255, 255, 255, 0, 0, 0));
      send_pixel(pixel(80, 160, 240, 200, 255, 10, 10, 10));

      for (int ph = 0; ph < PHASES; ph++) begin
         setup(pick_unorm(), pick_unorm(), pick_unorm(), pick_unorm(), 2'(ph % 4),
               (ph < 8) ? 1'((ph / 4) % 2) : 1'($urandom_range(1)));
         steady = (ph == 5);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (ph == 3 && n == PHASE_PIXELS / 2) drain_pipe();
            send_pixel(random_pixel());
         end
         steady = 1'b0;
      end

      drain_pipe();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/core/tpsb_pkg.sv
rtl/core/tpsb_req_if.sv
rtl/core/tpsb_rsp_if.sv
rtl/core/tpsb_csr_if.sv
rtl/core/tpsb_csr_regs.sv
rtl/core/tpsb_source_stages.sv
rtl/core/tpsb_blend_stages.sv
rtl/core/textured_pixel_shade_blend_core.sv
verif/tb_textured_pixel_shade_blend_core.sv
